@@ design/adcap_pkg.sv @@
// ----------------------------------------------------------------------------
// adcap_pkg
// Shared types and constants for the ADC capture and auto-range plotter.
// ----------------------------------------------------------------------------
package adcap_pkg;

    // Sample and plot widths
    localparam int SAMPLE_W = 10;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 9;
    localparam int BASE_W   = 8;
    localparam int CHAN_W   = 2;
    localparam int NCH_W    = 3;
    localparam int SCL_W    = 5;    // scaled offset always fits in five bits
    localparam int APB_AW   = 5;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'h3FF;

    // Register indexes on the APB port (byte address = 4 * index)
    localparam logic [2:0] REG_NUM_CHANNELS = 3'd0;
    localparam logic [2:0] REG_BASE_ROW0    = 3'd1;
    localparam logic [2:0] REG_BASE_ROW1    = 3'd2;
    localparam logic [2:0] REG_BASE_ROW2    = 3'd3;
    localparam logic [2:0] REG_BASE_ROW3    = 3'd4;

    // Register reset values
    localparam logic [NCH_W-1:0]  NUM_CHANNELS_RST = 3'd4;
    localparam logic [BASE_W-1:0] BASE_ROW0_RST    = 8'd8;
    localparam logic [BASE_W-1:0] BASE_ROW1_RST    = 8'd40;
    localparam logic [BASE_W-1:0] BASE_ROW2_RST    = 8'd72;
    localparam logic [BASE_W-1:0] BASE_ROW3_RST    = 8'd96;

    typedef enum logic [1:0] {
        OP_STORE   = 2'd0,
        OP_EMIT    = 2'd1,
        OP_RESTART = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        SCALE_NONE = 2'd0,
        SCALE_UP   = 2'd1,
        SCALE_DOWN = 2'd2
    } scale_mode_t;

    typedef logic [BASE_W-1:0] base_row_t;

    typedef struct packed {
        scale_mode_t mode;
        logic [2:0]  amount;   // right shift for SCALE_DOWN
    } scale_ctl_t;

    // Context of one plot point, handed from control to the output stage
    typedef struct packed {
        logic [COL_W-1:0]    column;
        logic [CHAN_W-1:0]   channel;
        logic                last;
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] range;
        scale_ctl_t          scale;
    } point_ctx_t;

    // Scaling from the highest set bit h of the range:
    // h >= 5 shifts right by h-4, h == 3 doubles, otherwise unchanged.
    function automatic scale_ctl_t scale_ctl(input logic [SAMPLE_W-1:0] delta);
        scale_ctl_t r;
        logic [3:0] h;
        logic       any;
        h   = 4'd0;
        any = 1'b0;
        for (int b = 0; b < SAMPLE_W; b++)
        begin
            if (delta[b])
            begin
                h   = 4'(b);
                any = 1'b1;
            end
        end
        r.mode   = SCALE_NONE;
        r.amount = 3'd0;
        if (any && h >= 4'd5)
        begin
            r.mode   = SCALE_DOWN;
            r.amount = 3'(h - 4'd4);
        end
        else if (any && h == 4'd3)
        begin
            r.mode = SCALE_UP;
        end
        return r;
    endfunction

endpackage

@@ design/adcap_sample_ram.sv @@
// ----------------------------------------------------------------------------
// adcap_sample_ram
// Sample buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module adcap_sample_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [adcap_pkg::SAMPLE_W-1:0] wdata,
    input  logic                           re,
    input  logic [AW-1:0]                  raddr,
    output logic [adcap_pkg::SAMPLE_W-1:0] rdata
);
    import adcap_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/adcap_ctrl.sv @@
// ----------------------------------------------------------------------------
// adcap_ctrl
// Capture control: fill and emit counters, channel/column walk and
// per-channel min/max tracking. Issues buffer reads for plot points.
// ----------------------------------------------------------------------------
module adcap_ctrl #(
    parameter int BUFFER_DEPTH = 128,
    parameter int AW           = 7,
    parameter int CW           = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_accept,
    input  adcap_pkg::opcode_t             opcode,
    input  logic [adcap_pkg::SAMPLE_W-1:0] sample,
    input  logic [adcap_pkg::NCH_W-1:0]    num_channels,
    output logic                           mem_we,
    output logic [AW-1:0]                  mem_waddr,
    output logic [adcap_pkg::SAMPLE_W-1:0] mem_wdata,
    output logic                           mem_re,
    output logic [AW-1:0]                  mem_raddr,
    output logic                           issue,
    output adcap_pkg::point_ctx_t          ctx
);
    import adcap_pkg::*;

    logic [CW-1:0]                  fill_count_reg, fill_count_next;
    logic [AW-1:0]                  emit_index_reg, emit_index_next;
    logic [COL_W-1:0]               column_reg, column_next;
    logic [CHAN_W-1:0]              chan_reg, chan_next;
    logic [3:0][SAMPLE_W-1:0]       min_reg, min_next;
    logic [3:0][SAMPLE_W-1:0]       max_reg, max_next;
    point_ctx_t                     ctx_reg, ctx_next;

    logic [NCH_W-1:0]    chan_cnt;
    logic                chan_wrap;
    logic                full;
    logic [SAMPLE_W-1:0] cur_min, cur_max, delta;

    // Effective channel count: 0 acts as 1, above 4 acts as 4
    always_comb
    begin
        case (num_channels)
            3'd0:                   chan_cnt = 3'd1;
            3'd1, 3'd2, 3'd3, 3'd4: chan_cnt = num_channels;
            default:                chan_cnt = 3'd4;
        endcase
    end

    assign chan_wrap = ({1'b0, chan_reg} + 3'd1) >= chan_cnt;
    assign full      = fill_count_reg >= CW'(BUFFER_DEPTH);
    assign cur_min   = min_reg[chan_reg];
    assign cur_max   = max_reg[chan_reg];
    assign delta     = (cur_max >= cur_min) ? (cur_max - cur_min) : '0;

    // Next state per accepted beat
    always_comb
    begin
        fill_count_next = fill_count_reg;
        emit_index_next = emit_index_reg;
        column_next     = column_reg;
        chan_next       = chan_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        ctx_next        = ctx_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        issue           = 1'b0;

        // channel walk, column wraps modulo 128
        if (chan_wrap)
        begin
            chan_next   = '0;
            column_next = column_reg + 7'd1;
        end
        else
        begin
            chan_next = chan_reg + 2'd1;
        end

        if (in_accept)
        begin
            case (opcode)
                OP_STORE:
                begin
                    if (!full)
                    begin
                        mem_we          = 1'b1;
                        fill_count_next = fill_count_reg + CW'(1);
                        if (sample < cur_min)
                        begin
                            min_next[chan_reg] = sample;
                        end
                        if (sample > cur_max)
                        begin
                            max_next[chan_reg] = sample;
                        end
                        // buffer now full: rewind for readout
                        if (fill_count_reg == CW'(BUFFER_DEPTH - 1))
                        begin
                            chan_next       = '0;
                            column_next     = '0;
                            emit_index_next = '0;
                        end
                    end
                    else
                    begin
                        chan_next   = chan_reg;
                        column_next = column_reg;
                    end
                end
                OP_EMIT:
                begin
                    if (full)
                    begin
                        mem_re           = 1'b1;
                        issue            = 1'b1;
                        ctx_next.column  = column_reg;
                        ctx_next.channel = chan_reg;
                        ctx_next.last    = emit_index_reg == AW'(BUFFER_DEPTH - 1);
                        ctx_next.minimum = cur_min;
                        ctx_next.range   = delta;
                        ctx_next.scale   = scale_ctl(delta);
                        if (ctx_next.last)
                        begin
                            fill_count_next = '0;
                            emit_index_next = '0;
                            column_next     = '0;
                            chan_next       = '0;
                            min_next        = {4{SAMPLE_MAX}};
                            max_next        = '0;
                        end
                        else
                        begin
                            emit_index_next = emit_index_reg + AW'(1);
                        end
                    end
                    else
                    begin
                        chan_next   = chan_reg;
                        column_next = column_reg;
                    end
                end
                OP_RESTART:
                begin
                    fill_count_next = '0;
                    emit_index_next = '0;
                    column_next     = '0;
                    chan_next       = '0;
                    min_next        = {4{SAMPLE_MAX}};
                    max_next        = '0;
                end
                default:
                begin
                    chan_next   = chan_reg;
                    column_next = column_reg;
                end
            endcase
        end
        else
        begin
            chan_next   = chan_reg;
            column_next = column_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            emit_index_reg <= '0;
            column_reg     <= '0;
            chan_reg       <= '0;
            min_reg        <= {4{SAMPLE_MAX}};
            max_reg        <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            emit_index_reg <= emit_index_next;
            column_reg     <= column_next;
            chan_reg       <= chan_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
        end
    end

    // Point context, payload only
    always_ff @(posedge clk)
    begin
        ctx_reg <= ctx_next;
    end

    assign mem_waddr = fill_count_reg[AW-1:0];
    assign mem_wdata = sample;
    assign mem_raddr = emit_index_reg;
    assign ctx       = ctx_reg;

endmodule

@@ design/adcap_scale_out.sv @@
// ----------------------------------------------------------------------------
// adcap_scale_out
// Scales the read-back sample into a plot row and holds the output beat.
// ----------------------------------------------------------------------------
module adcap_scale_out (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           issue,
    input  adcap_pkg::point_ctx_t          ctx,
    input  logic [adcap_pkg::SAMPLE_W-1:0] rdata,
    input  adcap_pkg::base_row_t [3:0]     base_row,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [15:0]                    m_tdata,
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    output logic                           take_ok
);
    import adcap_pkg::*;

    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg, row_val;
    logic [CHAN_W-1:0]   chan_reg;
    logic                last_reg;
    logic                out_free, load;
    logic [SAMPLE_W-1:0] offs, offs_cl, shifted;

    // Offset from channel minimum, clamped to the range
    always_comb
    begin
        offs    = (rdata >= ctx.minimum) ? (rdata - ctx.minimum) : '0;
        offs_cl = (offs > ctx.range) ? ctx.range : offs;
        case (ctx.scale.mode)
            SCALE_DOWN: shifted = offs_cl >> ctx.scale.amount;
            SCALE_UP:   shifted = offs_cl << 1;
            default:    shifted = offs_cl;
        endcase
        row_val = {1'b0, base_row[ctx.channel]} + ROW_W'(shifted[SCL_W-1:0]);
    end

    assign out_free       = !out_valid_reg || m_tready;
    assign load           = pend_reg && out_free;
    assign pend_next      = issue || (pend_reg && !load);
    assign out_valid_next = load || (out_valid_reg && !m_tready);
    assign take_ok        = !pend_reg || out_free;

    // Handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_reg  <= ctx.column;
            row_reg  <= row_val;
            chan_reg <= ctx.channel;
            last_reg <= ctx.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {row_reg, col_reg};
    assign m_tuser  = chan_reg;
    assign m_tlast  = last_reg;

endmodule

@@ design/adc_capture_autoscale_plotter.sv @@
// ----------------------------------------------------------------------------
// adc_capture_autoscale_plotter
// Captures a buffer of interleaved ADC samples with per-channel min/max
// and plays it back as auto-ranged plot points.
// ----------------------------------------------------------------------------
// Path: a store beat is registered into the control state; an emit beat
//   reaches the m side through the buffer read and the output register.
// Throughput: 1 beat per cycle while the output drains; a stalled output
//   beat with a point still pending holds s_tready low.
// Reset: rst_n clears counters, statistics and registers to their defaults
//   at once; the sample buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module adc_capture_autoscale_plotter #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [9:0] sample
    input  logic [1:0]                   s_tuser,   // [1:0] opcode
    // output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [6:0] column, [15:7] row
    output logic [1:0]                   m_tuser,   // [1:0] channel
    output logic                         m_tlast,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [adcap_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import adcap_pkg::*;

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [NCH_W-1:0]   num_channels_reg;
    base_row_t [3:0]    base_row_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    logic                in_accept;
    logic                mem_we, mem_re, issue;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [SAMPLE_W-1:0] mem_wdata, mem_rdata;
    point_ctx_t          ctx;
    logic                take_ok;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= NUM_CHANNELS_RST;
            base_row_reg[0]  <= BASE_ROW0_RST;
            base_row_reg[1]  <= BASE_ROW1_RST;
            base_row_reg[2]  <= BASE_ROW2_RST;
            base_row_reg[3]  <= BASE_ROW3_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_NUM_CHANNELS: num_channels_reg <= pwdata[NCH_W-1:0];
                REG_BASE_ROW0:    base_row_reg[0]  <= pwdata[BASE_W-1:0];
                REG_BASE_ROW1:    base_row_reg[1]  <= pwdata[BASE_W-1:0];
                REG_BASE_ROW2:    base_row_reg[2]  <= pwdata[BASE_W-1:0];
                REG_BASE_ROW3:    base_row_reg[3]  <= pwdata[BASE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (cfg_idx)
            REG_NUM_CHANNELS: prdata = 32'(num_channels_reg);
            REG_BASE_ROW0:    prdata = 32'(base_row_reg[0]);
            REG_BASE_ROW1:    prdata = 32'(base_row_reg[1]);
            REG_BASE_ROW2:    prdata = 32'(base_row_reg[2]);
            REG_BASE_ROW3:    prdata = 32'(base_row_reg[3]);
            default:          prdata = '0;
        endcase
    end

    assign s_tready  = take_ok;
    assign in_accept = s_tvalid && s_tready;

    adcap_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW),
        .CW           (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_accept    (in_accept),
        .opcode       (opcode_t'(s_tuser)),
        .sample       (s_tdata[SAMPLE_W-1:0]),
        .num_channels (num_channels_reg),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .issue        (issue),
        .ctx          (ctx)
    );

    adcap_sample_ram #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    adcap_scale_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .issue    (issue),
        .ctx      (ctx),
        .rdata    (mem_rdata),
        .base_row (base_row_reg),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .take_ok  (take_ok)
    );

endmodule

@@ design/adcap_checker.sv @@
// ----------------------------------------------------------------------------
// adcap_checker
// Port-level checks on the plotter's output stream.
// ----------------------------------------------------------------------------
module adcap_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Stalled output beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // Row never leaves the plot range
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:7] <= 9'd286)
        else $error("row out of range");

    // A fresh point follows an accepted input beat
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("point without a request");

    // No beat is offered once a reset edge has been taken
    a_rst: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind adc_capture_autoscale_plotter adcap_checker u_adcap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ verif/tb_adc_capture_autoscale_plotter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adc_capture_autoscale_plotter
// Self-checking bench for the ADC capture and auto-range plotter. Store,
// emit, restart and unused commands go in on the s side. A tracker class
// keeps its own copy of the capture buffer, the per-channel min/max, the
// counters and the registers, and predicts each plot point. Points seen on
// the m side are checked in order. Both sides idle and stall at random, and
// the registers are retuned over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_adc_capture_autoscale_plotter;

    import adcap_pkg::*;

    localparam int          BUF_DEPTH    = 128;
    localparam int          ITEMS        = 1600;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          SETTLE       = 4;     // cycles for a store to land
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    // Expected plot point
    typedef struct {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [CHAN_W-1:0] channel;
        logic              last;
    } plot_point_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;   // [9:0] sample
    logic [1:0]        s_tuser  = '0;   // [1:0] opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;         // [6:0] column, [15:7] row
    logic [1:0]        m_tuser;         // [1:0] channel
    logic              m_tlast;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    adc_capture_autoscale_plotter #(
        .BUFFER_DEPTH (BUF_DEPTH)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------------
    // Capture tracker: mirrors the buffer, statistics and registers, and
    // holds the plot points still to come out
    // ------------------------------------------------------------------------
    class plot_tracker;
        logic [NCH_W-1:0]    nch;
        logic [BASE_W-1:0]   base_row [4];
        logic [SAMPLE_W-1:0] samples [BUF_DEPTH];
        int unsigned         fill;
        int unsigned         emit_idx;
        logic [COL_W-1:0]    col;
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] ch_min [4];
        logic [SAMPLE_W-1:0] ch_max [4];
        plot_point_t         points_due [$];
        int                  errors;

        function new();
            nch         = NUM_CHANNELS_RST;
            base_row[0] = BASE_ROW0_RST;
            base_row[1] = BASE_ROW1_RST;
            base_row[2] = BASE_ROW2_RST;
            base_row[3] = BASE_ROW3_RST;
            errors      = 0;
            clear_capture();
        endfunction

        function void clear_capture();
            fill     = 0;
            emit_idx = 0;
            col      = '0;
            chan     = '0;
            for (int c = 0; c < 4; c++)
            begin
                ch_min[c] = SAMPLE_MAX;
                ch_max[c] = '0;
            end
        endfunction

        // Next channel; out-of-range counts clamp to 1..4
        function void step_channel();
            int unsigned n;
            n = (nch == 0) ? 1 : ((nch > 4) ? 4 : nch);
            if (chan + 1 >= n)
            begin
                chan = '0;
                col  = col + 1'b1;
            end
            else
            begin
                chan = chan + 1'b1;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_NUM_CHANNELS: nch         = val[NCH_W-1:0];
                REG_BASE_ROW0:    base_row[0] = val[BASE_W-1:0];
                REG_BASE_ROW1:    base_row[1] = val[BASE_W-1:0];
                REG_BASE_ROW2:    base_row[2] = val[BASE_W-1:0];
                REG_BASE_ROW3:    base_row[3] = val[BASE_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted command; an emit from a full buffer queues a point
        function void take_command(logic [1:0] op, logic [SAMPLE_W-1:0] smp);
            logic [CHAN_W-1:0]   ch;
            logic [SAMPLE_W-1:0] lo;
            logic [SAMPLE_W-1:0] hi;
            logic [SAMPLE_W-1:0] span;
            logic [SAMPLE_W-1:0] off;
            logic [SAMPLE_W-1:0] scaled;
            int                  msb;
            plot_point_t         pt;
            ch = chan;
            case (op)
                OP_RESTART:
                begin
                    clear_capture();
                end
                OP_STORE:
                begin
                    if (fill < BUF_DEPTH)
                    begin
                        samples[fill] = smp;
                        if (smp < ch_min[ch])
                            ch_min[ch] = smp;
                        if (smp > ch_max[ch])
                            ch_max[ch] = smp;
                        fill++;
                        step_channel();
                        if (fill >= BUF_DEPTH)
                        begin
                            chan     = '0;
                            col      = '0;
                            emit_idx = 0;
                        end
                    end
                end
                OP_EMIT:
                begin
                    if (fill >= BUF_DEPTH && emit_idx < BUF_DEPTH)
                    begin
                        lo   = ch_min[ch];
                        hi   = ch_max[ch];
                        // empty channel: min above max, range zero
                        span = (hi >= lo) ? hi - lo : '0;
                        off  = (samples[emit_idx] >= lo) ? samples[emit_idx] - lo : '0;
                        if (off > span)
                            off = span;
                        msb = -1;
                        for (int b = 0; b < SAMPLE_W; b++)
                            if (span[b])
                                msb = b;
                        if (msb >= 5)
                            scaled = off >> (msb - 4);
                        else if (msb == 3)
                            scaled = off << 1;
                        else
                            scaled = off;
                        pt.column  = col;
                        pt.row     = ROW_W'(base_row[ch]) + ROW_W'(scaled);
                        pt.channel = ch;
                        pt.last    = (emit_idx + 1 >= BUF_DEPTH);
                        points_due.push_back(pt);
                        if (pt.last)
                        begin
                            clear_capture();
                        end
                        else
                        begin
                            emit_idx++;
                            step_channel();
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_point(logic [COL_W-1:0] column, logic [ROW_W-1:0] row,
                                  logic [CHAN_W-1:0] channel, logic last);
            plot_point_t want;
            if (points_due.size() == 0)
            begin
                $error("unexpected point: column %0d row %0d channel %0d last %0b",
                       column, row, channel, last);
                errors++;
                return;
            end
            want = points_due.pop_front();
            if (column !== want.column)
            begin
                $error("column: expected %0d, got %0d", want.column, column);
                errors++;
            end
            if (row !== want.row)
            begin
                $error("row: expected %0d, got %0d", want.row, row);
                errors++;
            end
            if (channel !== want.channel)
            begin
                $error("channel: expected %0d, got %0d", want.channel, channel);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return points_due.size();
        endfunction
    endclass

    plot_tracker tracker = new();

    // Stimulus shaping shared between tasks and processes
    int  beats_sent  = 0;
    bit  gaps_on     = 1'b1;
    bit  hold_req    = 1'b0;
    bit  hold_done   = 1'b0;
    int  hold_left   = 0;
    int  steady_left = 0;
    int  stall_left  = 0;
    int  rx_roll;

    // Clock
    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Receiver: random stalls, quiet stretches, and one long hold on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (steady_left > 0)
        begin
            steady_left--;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 3)
            begin
                steady_left = $urandom_range(30, 150);
                m_tready <= 1'b1;
            end
            else if (rx_roll < 22)
            begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else if (rx_roll < 25)
            begin
                stall_left = $urandom_range(10, 40);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_point(m_tdata[COL_W-1:0], m_tdata[COL_W+ROW_W-1:COL_W],
                                m_tuser, m_tlast);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One beat on the s side, then an optional gap
    task automatic send_beat(logic [1:0] op, logic [SAMPLE_W-1:0] smp);
        int r;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, smp};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_command(op, smp);
        beats_sent++;
        gap = 0;
        if (gaps_on)
        begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(10, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid, drain all points, let the last store settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write: setup, access, then back to idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_base();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Sample at or above a centre within a spread of 2**spread_log, saturated
    function automatic logic [SAMPLE_W-1:0] pick_sample(int centre, int spread_log);
        int v;
        if ($urandom_range(0, 99) < 3)
            return $urandom_range(0, 1) ? SAMPLE_MAX : '0;
        v = centre + $urandom_range(0, (1 << spread_log) - 1);
        return (v > 1023) ? SAMPLE_MAX : SAMPLE_W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int round;
        int centre;
        int spread_log;
        int fill_len;
        int emit_len;
        int switch_at;
        int r;
        logic [2:0] nch_order [8];
        nch_order = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd5, 3'd3, 3'd6};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, field extremes, ignored and restart cases
        send_beat(OP_STORE,   10'd0);
        send_beat(OP_STORE,   SAMPLE_MAX);
        send_beat(OP_STORE,   10'h155);
        send_beat(OP_STORE,   10'h2AA);
        send_beat(OP_UNUSED,  SAMPLE_MAX);
        send_beat(OP_EMIT,    10'd0);          // buffer not full, no point
        send_beat(OP_RESTART, 10'h2AA);
        send_beat(OP_EMIT,    SAMPLE_MAX);
        send_beat(OP_STORE,   10'd512);
        send_beat(OP_RESTART, 10'd0);

        round = 0;
        while (beats_sent < ITEMS)
        begin
            // Retune all registers while idle
            wait_idle();
            write_reg(REG_NUM_CHANNELS, {29'd0, (round < 8) ? nch_order[round]
                                                            : 3'($urandom_range(0, 7))});
            write_reg(REG_BASE_ROW0, {24'd0, pick_base()});
            write_reg(REG_BASE_ROW1, {24'd0, pick_base()});
            write_reg(REG_BASE_ROW2, {24'd0, pick_base()});
            write_reg(REG_BASE_ROW3, {24'd0, pick_base()});

            gaps_on    = ($urandom_range(0, 3) != 0);
            spread_log = $urandom_range(0, 10);
            centre     = $urandom_range(0, 1023);

            // Fill, with a little noise and perhaps a channel count change
            fill_len  = BUF_DEPTH + $urandom_range(0, 3);
            switch_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, BUF_DEPTH - 1) : -1;
            for (int i = 0; i < fill_len; i++)
            begin
                if (i == switch_at)
                begin
                    wait_idle();
                    write_reg(REG_NUM_CHANNELS, {29'd0, 3'($urandom_range(0, 7))});
                end
                r = $urandom_range(0, 999);
                if (r < 930)
                    send_beat(OP_STORE, pick_sample(centre, spread_log));
                else if (r < 960)
                    send_beat(OP_EMIT, SAMPLE_W'($urandom_range(0, 1023)));
                else if (r < 997)
                    send_beat(OP_UNUSED, SAMPLE_W'($urandom_range(0, 1023)));
                else
                    send_beat(OP_RESTART, SAMPLE_W'($urandom_range(0, 1023)));
            end

            // Play back; the second round holds the receiver off for a while
            if (round == 1)
            begin
                gaps_on  = 1'b0;
                hold_req = 1'b1;
            end
            emit_len  = BUF_DEPTH + $urandom_range(0, 2);
            switch_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, BUF_DEPTH - 1) : -1;
            for (int i = 0; i < emit_len; i++)
            begin
                if (i == switch_at)
                begin
                    wait_idle();
                    write_reg(REG_NUM_CHANNELS, {29'd0, 3'($urandom_range(0, 7))});
                end
                r = $urandom_range(0, 999);
                if (r < 950)
                    send_beat(OP_EMIT, SAMPLE_W'($urandom_range(0, 1023)));
                else if (r < 975)
                    send_beat(OP_STORE, SAMPLE_W'($urandom_range(0, 1023)));
                else if (r < 997)
                    send_beat(OP_UNUSED, SAMPLE_W'($urandom_range(0, 1023)));
                else
                    send_beat(OP_RESTART, SAMPLE_W'($urandom_range(0, 1023)));
            end
            round++;
        end

        // Drain and report
        wait_idle();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/adcap_pkg.sv
design/adcap_sample_ram.sv
design/adcap_ctrl.sv
design/adcap_scale_out.sv
design/adc_capture_autoscale_plotter.sv
design/adcap_checker.sv
verif/tb_adc_capture_autoscale_plotter.sv
